FILE: rtl/core/sbc_pkg.sv
package sbc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int MAX_FOLDS_DEF   = 6;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 8;

  // Group queue between the front pipeline and the output expander
  localparam int QUEUE_DEPTH    = 8;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam int LEVEL_BITS = 32;
  localparam int FOLD_BITS  = 3;
  localparam int DEPTH_BITS = 6;
  localparam int MIX_BITS   = 8;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEPTH_BITS = 2'd0,
    REG_MASK_MIX   = 2'd1,
    REG_FOLD_LOG2  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth_bits;
    logic [MIX_BITS-1:0]   mask_mix;
    logic [FOLD_BITS-1:0]  fold_log2;
  } crush_cfg_t;

  // One finished group: crushed level and the fold that sets its repeat count
  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic [FOLD_BITS-1:0]  fold;
  } grp_entry_t;

  typedef struct packed {
    logic [QUEUE_CNT_BITS-1:0] fill;
    logic                      empty;
  } queue_status_t;

endpackage

FILE: rtl/core/sbc_front.sv
module sbc_front import sbc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_FOLDS   = MAX_FOLDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  crush_cfg_t                    cfg,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  queue_status_t                 qstat,
  output logic                          wr_en,
  output grp_entry_t                    wr_entry
);

  localparam int SUM_BITS   = SAMPLE_BITS + MAX_FOLDS;
  localparam int CNT_BITS   = (MAX_FOLDS > 0) ? MAX_FOLDS : 1;
  localparam int SCALE_BITS = SAMPLE_BITS + 31;
  localparam int OCC_BITS   = QUEUE_CNT_BITS + 1;

  logic [FOLD_BITS-1:0]       fold_eff;
  logic [CNT_BITS-1:0]        len_mask;
  logic [CNT_BITS-1:0]        group_count;
  logic signed [SUM_BITS-1:0] group_sum;
  logic signed [SUM_BITS-1:0] sum_next;
  logic                       accept;
  logic                       group_end;

  // stage 1: finished group sum
  logic                       v1;
  logic signed [SUM_BITS-1:0] s1_sum;
  logic [FOLD_BITS-1:0]       s1_fold;
  // stage 2: saturated mean as sign and magnitude
  logic                       v2;
  logic                       s2_neg;
  logic [SAMPLE_BITS-1:0]     s2_mag;
  logic [FOLD_BITS-1:0]       s2_fold;
  // stage 3: magnitude scaled to Q0.31
  logic                       v3;
  logic                       s3_neg;
  logic [LEVEL_BITS-1:0]      s3_x;
  logic [FOLD_BITS-1:0]       s3_fold;
  // stage 4: signed Q0.31 level
  logic                       v4;
  logic [LEVEL_BITS-1:0]      s4_ux;
  logic [FOLD_BITS-1:0]       s4_fold;

  logic [SUM_BITS-1:0]        abs_sum;
  logic [SUM_BITS-1:0]        mean_mag;
  logic [SUM_BITS-1:0]        mean_lim;
  logic [SUM_BITS-1:0]        mean_sat;
  logic [SCALE_BITS-1:0]      scale_prod;

  logic [DEPTH_BITS-1:0]      depth_eff;
  logic                       full_depth;
  logic [4:0]                 below_pos;
  logic [LEVEL_BITS-1:0]      top_mask;
  logic                       below_set;
  logic [LEVEL_BITS+MIX_BITS-1:0] blend_wide;
  logic [LEVEL_BITS-1:0]      blend;
  logic [OCC_BITS-1:0]        occupancy;

  assign fold_eff  = (cfg.fold_log2 > MAX_FOLDS) ? FOLD_BITS'(MAX_FOLDS) : cfg.fold_log2;
  assign len_mask  = CNT_BITS'((1 << fold_eff) - 1);
  assign group_end = (group_count & len_mask) == len_mask;
  assign sum_next  = group_sum + SUM_BITS'(sample_in);
  assign accept    = in_valid & in_ready;

  // Hold input while queue plus words in flight could overrun the queue
  assign occupancy = OCC_BITS'(qstat.fill) + OCC_BITS'(v1) + OCC_BITS'(v2)
                   + OCC_BITS'(v3) + OCC_BITS'(v4);
  assign in_ready  = occupancy < OCC_BITS'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= '0;
      group_sum   <= '0;
      v1          <= 1'b0;
    end else begin
      v1 <= accept & group_end;
      if (accept) begin
        group_count <= group_count + CNT_BITS'(1);
        group_sum   <= group_end ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && group_end) begin
      s1_sum  <= sum_next;
      s1_fold <= fold_eff;
    end
  end

  // Mean truncates toward zero: shift the magnitude, then saturate
  assign abs_sum  = s1_sum[SUM_BITS-1] ? SUM_BITS'(-s1_sum) : SUM_BITS'(s1_sum);
  assign mean_mag = abs_sum >> s1_fold;
  assign mean_lim = s1_sum[SUM_BITS-1] ? (SUM_BITS'(1) << (SAMPLE_BITS - 1))
                                       : ((SUM_BITS'(1) << (SAMPLE_BITS - 1)) - SUM_BITS'(1));
  assign mean_sat = (mean_mag > mean_lim) ? mean_lim : mean_mag;

  // mag * (2^31 - 1), then drop SAMPLE_BITS-1 fraction bits
  assign scale_prod = {s2_mag, 31'b0} - SCALE_BITS'(s2_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s2_neg  <= s1_sum[SUM_BITS-1];
    s2_mag  <= mean_sat[SAMPLE_BITS-1:0];
    s2_fold <= s1_fold;
    s3_neg  <= s2_neg;
    s3_x    <= scale_prod[SCALE_BITS-1 -: LEVEL_BITS];
    s3_fold <= s2_fold;
    s4_ux   <= s3_neg ? -s3_x : s3_x;
    s4_fold <= s3_fold;
  end

  // Quantise to the top bits, blend in the bit just below by mask_mix/256
  always_comb begin
    if (cfg.depth_bits == '0) begin
      depth_eff = DEPTH_BITS'(1);
    end else if (cfg.depth_bits > DEPTH_BITS'(32)) begin
      depth_eff = DEPTH_BITS'(32);
    end else begin
      depth_eff = cfg.depth_bits;
    end
  end

  assign full_depth = depth_eff == DEPTH_BITS'(32);
  assign below_pos  = 5'(DEPTH_BITS'(31) - depth_eff);
  assign top_mask   = full_depth ? '1 : ~({LEVEL_BITS{1'b1}} >> depth_eff);
  assign below_set  = !full_depth && s4_ux[below_pos];
  assign blend_wide = ((LEVEL_BITS+MIX_BITS)'(cfg.mask_mix) << below_pos) >> MIX_BITS;
  assign blend      = below_set ? blend_wide[LEVEL_BITS-1:0] : '0;

  assign wr_en          = v4;
  assign wr_entry.level = (s4_ux & top_mask) + blend;
  assign wr_entry.fold  = s4_fold;

endmodule

FILE: rtl/core/sbc_queue.sv
module sbc_queue import sbc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  grp_entry_t    push_entry,
  input  logic          pop,
  output grp_entry_t    head,
  output queue_status_t qstat
);

  grp_entry_t                mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + QUEUE_CNT_BITS'(1);
        2'b01:   fill <= fill - QUEUE_CNT_BITS'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  assign head        = mem[rd_ptr];
  assign qstat.fill  = fill;
  assign qstat.empty = fill == '0;

endmodule

FILE: rtl/core/sbc_back.sv
module sbc_back import sbc_pkg::*; #(
  parameter int MAX_FOLDS = MAX_FOLDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  grp_entry_t                   head,
  input  queue_status_t                qstat,
  output logic                         pop,
  output logic signed [LEVEL_BITS-1:0] sample_out,
  output logic                         last_of_group,
  output logic                         out_valid,
  input  logic                         out_ready
);

  localparam int CNT_BITS = (MAX_FOLDS > 0) ? MAX_FOLDS : 1;

  logic [CNT_BITS-1:0] repeat_cnt;
  logic [CNT_BITS-1:0] len_mask;
  logic                load;
  logic                final_copy;

  assign len_mask   = CNT_BITS'((1 << head.fold) - 1);
  assign final_copy = repeat_cnt == len_mask;
  assign load       = !qstat.empty && (!out_valid || out_ready);
  // Drop the group from the queue once its last copy is issued
  assign pop        = load && final_copy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      repeat_cnt <= '0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
      if (load) begin
        repeat_cnt <= final_copy ? '0 : repeat_cnt + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_out    <= head.level;
      last_of_group <= final_copy;
    end
  end

endmodule

FILE: rtl/core/sample_rate_and_bit_crusher_top.sv
// Decimating bit crusher. One signed sample is taken per clock while in_ready
// is high; samples are summed in groups of 2^fold_log2 (capped at MAX_FOLDS),
// and at the end of each group the mean is scaled to Q0.31, cut to depth_bits
// top bits with mask_mix/256 of the next bit blended in, and sent out
// 2^fold_log2 times, the final copy flagged by last_of_group. Input and
// output each move one word per clock unless held by in_ready or out_ready;
// the output port, at one word per clock, sets the sustained rate. A group's
// result passes from its last sample through the group sum, mean, scale and
// quantise registers into the queue, then the output register. An eight-entry
// group queue lets the input side run ahead while a stalled output drains;
// input ready drops only when queue and pipeline together hold eight groups.
module sample_rate_and_bit_crusher_top import sbc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MAX_FOLDS   = MAX_FOLDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic signed [LEVEL_BITS-1:0]  sample_out,
  output logic                          last_of_group,
  output logic                          out_valid,
  input  logic                          out_ready
);

  crush_cfg_t    cfg;
  queue_status_t qstat;
  grp_entry_t    wr_entry;
  grp_entry_t    head;
  logic          wr_en;
  logic          pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_bits <= DEPTH_BITS'(32);
      cfg.mask_mix   <= '0;
      cfg.fold_log2  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEPTH_BITS: cfg.depth_bits <= cfg_data[DEPTH_BITS-1:0];
        REG_MASK_MIX:   cfg.mask_mix   <= cfg_data[MIX_BITS-1:0];
        REG_FOLD_LOG2:  cfg.fold_log2  <= cfg_data[FOLD_BITS-1:0];
        default:        cfg            <= cfg;
      endcase
    end
  end

  sbc_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_FOLDS   (MAX_FOLDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_in (sample_in),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .qstat     (qstat),
    .wr_en     (wr_en),
    .wr_entry  (wr_entry)
  );

  sbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (wr_en),
    .push_entry (wr_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  sbc_back #(
    .MAX_FOLDS (MAX_FOLDS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .sample_out    (sample_out),
    .last_of_group (last_of_group),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

endmodule
